>>> hdl/cdc_pkg.sv
// Shared types and constants for the content-defined chunker.
// Used by every module in this folder; depends on nothing.
package cdc_pkg;

  // Gear table geometry (fixed)
  localparam int unsigned GearEntries = 256;
  localparam int unsigned GearAddrW   = $clog2(GearEntries);
  localparam int unsigned GearW       = 64;

  // Default widths of the length counter and the stream offset
  localparam int unsigned LengthBitsDef = 32;
  localparam int unsigned OffsetBitsDef = 48;

  // Configuration port geometry
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgLenW  = 32;

  // Register reset values
  localparam logic [CfgLenW-1:0] MinLenRst = 32'd2048;
  localparam logic [CfgLenW-1:0] AvgLenRst = 32'd8192;
  localparam logic [GearW-1:0]   MaskRst   = 64'd0;

  // Register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    RegMinLen    = 2'd0,
    RegAvgLen    = 2'd1,
    RegMaskSmall = 2'd2,
    RegMaskLarge = 2'd3
  } cfg_reg_e;

  // Input item kind carried on tuser
  localparam logic ModeTable = 1'b0;
  localparam logic ModeData  = 1'b1;

  // Input tdata layout: table_index, table_word, data_byte
  localparam int unsigned InDataW = 80;

  // Live configuration handed to the cut logic
  typedef struct packed {
    logic [CfgLenW-1:0] min_length;
    logic [CfgLenW-1:0] average_length;
    logic [GearW-1:0]   mask_small;
    logic [GearW-1:0]   mask_large;
  } cfg_t;

endpackage

>>> hdl/content_defined_chunker.sv
// Content-defined chunker, gear hash with small/large mask normalization.
// Throughput: one item per cycle; the hash recurrence closes through hash_q alone. The input
// stalls only while a result waits unaccepted and the byte in the hash stage ends a chunk.
// Result path: the byte that ends a chunk passes the lookup stage (gear word and s1 registers),
// then the result register that drives m_axis_tvalid; a full result register holds it back.
// Reset: registers, counters and hash return to defaults at once; the gear table keeps its words.
module content_defined_chunker #(
  parameter int unsigned LengthBits = cdc_pkg::LengthBitsDef,
  parameter int unsigned OffsetBits = cdc_pkg::OffsetBitsDef,
  localparam int unsigned OutDataW  = ((OffsetBits + LengthBits + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cdc_pkg::CfgAddrW-1:0] paddr,
  input  logic [cdc_pkg::CfgDataW-1:0] pwdata,
  output logic [cdc_pkg::CfgDataW-1:0] prdata,
  output logic                         pready,
  // Input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [cdc_pkg::InDataW-1:0]  s_axis_tdata,  // table_index, table_word, data_byte
  input  logic                         s_axis_tuser,  // mode
  input  logic                         s_axis_tlast,  // last_byte
  // Result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [OutDataW-1:0]          m_axis_tdata,  // chunk_offset, chunk_length, zero pad
  output logic                         m_axis_tlast   // final_chunk
);

  cdc_pkg::cfg_t             cfg;
  logic                      in_xfer;
  logic                      tbl_wr;
  logic                      data_rd;
  logic [cdc_pkg::GearW-1:0] gear_word;
  logic [OffsetBits-1:0]     out_offset;
  logic [LengthBits-1:0]     out_length;

  // Decode the input transfer
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign tbl_wr  = in_xfer && (s_axis_tuser == cdc_pkg::ModeTable);
  assign data_rd = in_xfer && (s_axis_tuser == cdc_pkg::ModeData);

  cdc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cdc_gear_mem u_gear (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_wr),
    .wr_addr_i (s_axis_tdata[7:0]),
    .wr_data_i (s_axis_tdata[71:8]),
    .rd_en_i   (data_rd),
    .rd_addr_i (s_axis_tdata[79:72]),
    .rd_data_o (gear_word)
  );

  cdc_cut_engine #(
    .LengthBits (LengthBits),
    .OffsetBits (OffsetBits)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .issue_i      (data_rd),
    .last_i       (s_axis_tlast),
    .gear_word_i  (gear_word),
    .ready_o      (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_offset_o (out_offset),
    .out_length_o (out_length),
    .out_final_o  (m_axis_tlast)
  );

  // Pack the result fields, offset in the low bits
  assign m_axis_tdata = OutDataW'({out_length, out_offset});

endmodule

>>> hdl/cdc_gear_mem.sv
// Gear table: single-port-write, single-read synchronous memory.
// Read data is registered. Depends on cdc_pkg.
module cdc_gear_mem (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [cdc_pkg::GearAddrW-1:0] wr_addr_i,
  input  logic [cdc_pkg::GearW-1:0]     wr_data_i,
  input  logic                          rd_en_i,
  input  logic [cdc_pkg::GearAddrW-1:0] rd_addr_i,
  output logic [cdc_pkg::GearW-1:0]     rd_data_o
);

  logic [cdc_pkg::GearW-1:0] mem_q [cdc_pkg::GearEntries];
  logic [cdc_pkg::GearW-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/cdc_cfg_regs.sv
// APB register file for the chunker: cut thresholds and hash masks.
// Depends on cdc_pkg for the register map and reset values.
module cdc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cdc_pkg::CfgAddrW-1:0] paddr,
  input  logic [cdc_pkg::CfgDataW-1:0] pwdata,
  output logic [cdc_pkg::CfgDataW-1:0] prdata,
  output logic                         pready,
  output cdc_pkg::cfg_t                cfg_o
);

  cdc_pkg::cfg_t     cfg_q;
  cdc_pkg::cfg_reg_e reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cdc_pkg::cfg_reg_e'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite;

  // Register writes on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_length     <= cdc_pkg::MinLenRst;
      cfg_q.average_length <= cdc_pkg::AvgLenRst;
      cfg_q.mask_small     <= cdc_pkg::MaskRst;
      cfg_q.mask_large     <= cdc_pkg::MaskRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        cdc_pkg::RegMinLen:    cfg_q.min_length     <= pwdata[cdc_pkg::CfgLenW-1:0];
        cdc_pkg::RegAvgLen:    cfg_q.average_length <= pwdata[cdc_pkg::CfgLenW-1:0];
        cdc_pkg::RegMaskSmall: cfg_q.mask_small     <= pwdata;
        cdc_pkg::RegMaskLarge: cfg_q.mask_large     <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      cdc_pkg::RegMinLen:    prdata = {32'd0, cfg_q.min_length};
      cdc_pkg::RegAvgLen:    prdata = {32'd0, cfg_q.average_length};
      cdc_pkg::RegMaskSmall: prdata = cfg_q.mask_small;
      cdc_pkg::RegMaskLarge: prdata = cfg_q.mask_large;
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/cdc_cut_engine.sv
// Gear hash update, cut decision and result register of the chunker.
// Takes the registered gear word from cdc_gear_mem; depends on cdc_pkg.
module cdc_cut_engine #(
  parameter int unsigned LengthBits = cdc_pkg::LengthBitsDef,
  parameter int unsigned OffsetBits = cdc_pkg::OffsetBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cdc_pkg::cfg_t             cfg_i,
  input  logic                      issue_i,
  input  logic                      last_i,
  input  logic [cdc_pkg::GearW-1:0] gear_word_i,
  output logic                      ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [OffsetBits-1:0]     out_offset_o,
  output logic [LengthBits-1:0]     out_length_o,
  output logic                      out_final_o
);

  localparam int unsigned CmpW = (LengthBits > cdc_pkg::CfgLenW) ? LengthBits
                                                                 : cdc_pkg::CfgLenW;

  logic                      s1_valid_q;
  logic                      s1_last_q;
  logic [cdc_pkg::GearW-1:0] hash_q;
  logic [LengthBits-1:0]     count_q;
  logic [OffsetBits-1:0]     start_q;
  logic [OffsetBits-1:0]     pos_q;
  logic                      out_valid_q;
  logic [OffsetBits-1:0]     out_offset_q;
  logic [LengthBits-1:0]     out_length_q;
  logic                      out_final_q;

  logic [cdc_pkg::GearW-1:0] hash_sum;
  logic [cdc_pkg::GearW-1:0] mask;
  logic [CmpW-1:0]           count_ext;
  logic [CmpW-1:0]           min_ext;
  logic [CmpW-1:0]           avg_ext;
  logic [LengthBits-1:0]     count_inc;
  logic [OffsetBits-1:0]     pos_inc;
  logic                      cut;
  logic                      emit;
  logic                      out_free;
  logic                      advance;

  // Hash recurrence and mask select
  always_comb begin
    hash_sum  = {hash_q[cdc_pkg::GearW-2:0], 1'b0} + gear_word_i;
    count_ext = CmpW'(count_q);
    min_ext   = CmpW'(cfg_i.min_length);
    avg_ext   = CmpW'(cfg_i.average_length);
    mask      = (count_ext < avg_ext) ? cfg_i.mask_small : cfg_i.mask_large;
    cut       = (count_ext >= min_ext) && ((hash_sum & mask) == '0);
    count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
    pos_inc   = pos_q + 1'b1;
  end

  // Stage handshake: stall only when a result finds the output register full and not being read
  assign emit     = s1_valid_q && (cut || s1_last_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = s1_valid_q && (!emit || out_free);
  assign ready_o  = !s1_valid_q || advance;

  // Lookup stage: item waits here for its gear word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (ready_o) begin
      s1_valid_q <= issue_i;
      s1_last_q  <= last_i;
    end
  end

  // Chunk state: hash, length count, chunk start, stream position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= '0;
      count_q <= '0;
      start_q <= '0;
      pos_q   <= '0;
    end else if (advance) begin
      pos_q <= pos_inc;
      if (emit) begin
        hash_q  <= '0;
        count_q <= '0;
        start_q <= pos_inc;
      end else begin
        hash_q  <= hash_sum;
        count_q <= count_inc;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_offset_q <= start_q;
      out_length_q <= count_inc;
      out_final_q  <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_offset_o = out_offset_q;
  assign out_length_o = out_length_q;
  assign out_final_o  = out_final_q;

endmodule

>>> sim/cdc_chunk_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the content-defined chunker: snoops the configuration port and
// both streams, predicts every chunk and compares it field by field.
// Depends on cdc_pkg for register indexes, input modes and reset values.
module cdc_chunk_checker #(
  parameter int unsigned LengthBits = cdc_pkg::LengthBitsDef,
  parameter int unsigned OffsetBits = cdc_pkg::OffsetBitsDef,
  localparam int unsigned OutDataW  = ((OffsetBits + LengthBits + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cdc_pkg::CfgAddrW-1:0] paddr,
  input  logic [cdc_pkg::CfgDataW-1:0] pwdata,
  input  logic                         pready,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [cdc_pkg::InDataW-1:0]  s_axis_tdata,  // table_index, table_word, data_byte
  input  logic                         s_axis_tuser,  // mode
  input  logic                         s_axis_tlast,  // last_byte
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [OutDataW-1:0]          m_axis_tdata,  // chunk_offset, chunk_length, zero pad
  input  logic                         m_axis_tlast,  // final_chunk
  input  logic                         flush_i,
  output int                           pending_o,
  output int                           fail_count_o
);

  typedef struct packed {
    logic [OffsetBits-1:0] offset;
    logic [LengthBits-1:0] length;
    logic                  ends_buffer;
  } chunk_t;

  // Shadow of the block's registers and chunking state
  logic [cdc_pkg::CfgLenW-1:0] min_len_q;
  logic [cdc_pkg::CfgLenW-1:0] avg_len_q;
  logic [cdc_pkg::GearW-1:0]   mask_small_q;
  logic [cdc_pkg::GearW-1:0]   mask_large_q;
  logic [cdc_pkg::GearW-1:0]   gear_q [cdc_pkg::GearEntries];
  logic [cdc_pkg::GearW-1:0]   hash_q;
  logic [OffsetBits-1:0]       start_q;
  logic [OffsetBits-1:0]       pos_q;
  logic [LengthBits-1:0]       count_q;

  chunk_t chunks_due [$];

  task automatic flag_mismatch(input string what);
    $display("chunk check at %0t ns: %s", $time, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track_chunks
    logic [cdc_pkg::GearW-1:0] hash_nx;
    logic [cdc_pkg::GearW-1:0] mask_sel;
    logic [LengthBits-1:0]     len_nx;
    logic                      cut;
    chunk_t                    got;
    chunk_t                    want;
    if (!rst_ni) begin
      min_len_q    = cdc_pkg::MinLenRst;
      avg_len_q    = cdc_pkg::AvgLenRst;
      mask_small_q = cdc_pkg::MaskRst;
      mask_large_q = cdc_pkg::MaskRst;
      hash_q       = '0;
      start_q      = '0;
      pos_q        = '0;
      count_q      = '0;
      chunks_due.delete();
      pending_o   <= 0;
    end else begin
      // Compare a result transfer with the oldest predicted chunk
      if (m_axis_tvalid && m_axis_tready) begin
        got.offset      = m_axis_tdata[OffsetBits-1:0];
        got.length      = m_axis_tdata[OffsetBits+LengthBits-1:OffsetBits];
        got.ends_buffer = m_axis_tlast;
        if (chunks_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected chunk offset %0d length %0d",
                                  got.offset, got.length));
        end else begin
          want = chunks_due.pop_front();
          if (got.offset != want.offset)
            flag_mismatch($sformatf("chunk_offset got %0d want %0d", got.offset, want.offset));
          if (got.length != want.length)
            flag_mismatch($sformatf("chunk_length got %0d want %0d", got.length, want.length));
          if (got.ends_buffer != want.ends_buffer)
            flag_mismatch($sformatf("final_chunk got %0b want %0b",
                                    got.ends_buffer, want.ends_buffer));
        end
      end

      // Mirror register writes
      if (psel && penable && pwrite && pready) begin
        case (cdc_pkg::cfg_reg_e'(paddr[cdc_pkg::CfgAddrW-1:3]))
          cdc_pkg::RegMinLen:    min_len_q    = pwdata[cdc_pkg::CfgLenW-1:0];
          cdc_pkg::RegAvgLen:    avg_len_q    = pwdata[cdc_pkg::CfgLenW-1:0];
          cdc_pkg::RegMaskSmall: mask_small_q = pwdata[cdc_pkg::GearW-1:0];
          cdc_pkg::RegMaskLarge: mask_large_q = pwdata[cdc_pkg::GearW-1:0];
          default: ;
        endcase
      end

      // Advance the predictor on an input transfer
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == cdc_pkg::ModeTable) begin
          gear_q[s_axis_tdata[7:0]] = s_axis_tdata[71:8];
        end else begin
          hash_nx = (hash_q << 1) + gear_q[s_axis_tdata[79:72]];
          cut     = 1'b0;
          if (count_q >= min_len_q) begin
            mask_sel = (count_q < avg_len_q) ? mask_small_q : mask_large_q;
            cut      = (hash_nx & mask_sel) == '0;
          end
          len_nx = (count_q == '1) ? count_q : count_q + 1'b1;
          if (cut || s_axis_tlast) begin
            chunks_due.push_back('{offset: start_q, length: len_nx, ends_buffer: s_axis_tlast});
            hash_q  = '0;
            count_q = '0;
            start_q = pos_q + 1'b1;
          end else begin
            hash_q  = hash_nx;
            count_q = len_nx;
          end
          pos_q = pos_q + 1'b1;
        end
      end

      // Flag whatever is still expected at the end of the run as missing
      if (flush_i) begin
        while (chunks_due.size() != 0) begin
          want = chunks_due.pop_front();
          flag_mismatch($sformatf("missing chunk offset %0d length %0d",
                                  want.offset, want.length));
        end
      end

      pending_o <= chunks_due.size();
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Top of the chunker testbench: clock, reset, register setup and stream traffic.
// Instantiates content_defined_chunker and cdc_chunk_checker; uses cdc_pkg.
module tb;

  localparam int unsigned OutDataW     =
    ((cdc_pkg::OffsetBitsDef + cdc_pkg::LengthBitsDef + 7) / 8) * 8;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseItems   = 125;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainLimit   = 100000;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [cdc_pkg::CfgAddrW-1:0] paddr;
  logic [cdc_pkg::CfgDataW-1:0] pwdata;
  logic [cdc_pkg::CfgDataW-1:0] prdata;
  logic                         pready;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [cdc_pkg::InDataW-1:0]  s_axis_tdata;  // table_index, table_word, data_byte
  logic                         s_axis_tuser;  // mode
  logic                         s_axis_tlast;  // last_byte
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [OutDataW-1:0]          m_axis_tdata;  // chunk_offset, chunk_length, zero pad
  logic                         m_axis_tlast;  // final_chunk
  logic                         flush;
  int                           pending;
  int                           fail_count;

  idle_e       idle_mode = IdleNone;
  int          hold_reqs = 0;
  int unsigned items_sent = 0;
  bit          loaded [cdc_pkg::GearEntries];
  logic [7:0]  loaded_list [$];

  always #2 clk_i = ~clk_i;

  content_defined_chunker DUT (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  cdc_chunk_checker u_check (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .flush_i      (flush),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Mask with up to the given number of bits set at random positions
  function automatic logic [63:0] sparse_mask(input int bits);
    logic [63:0] m;
    m = '0;
    repeat (bits) m[$urandom_range(63)] = 1'b1;
    return m;
  endfunction

  function automatic bit sender_waits();
    case (idle_mode)
      IdleSender: return $urandom_range(99) < 87;
      IdleBoth:   return $urandom_range(99) < 9;
      default:    return 1'b0;
    endcase
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(input logic mode, input logic [7:0] index, input logic [63:0] word,
                           input logic [7:0] data, input logic last);
    @(negedge clk_i);
    while (sender_waits()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {data, word, index};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_table(input logic [7:0] index, input logic [63:0] word);
    send_item(cdc_pkg::ModeTable, index, word, 8'($urandom), 1'($urandom));
    if (!loaded[index]) begin
      loaded[index] = 1'b1;
      loaded_list.push_back(index);
    end
  endtask

  task automatic send_data(input logic [7:0] data, input logic last);
    send_item(cdc_pkg::ModeData, 8'($urandom), random_word(), data, last);
  endtask

  // One buffer of loaded bytes, sometimes preceded or broken up by table writes
  task automatic send_random_buffer();
    int unsigned len;
    int unsigned writes;
    logic [7:0]  b;
    if ($urandom_range(99) < 30) begin
      writes = $urandom_range(1, 6);
      repeat (writes) send_table(8'($urandom), random_word());
    end
    len = ($urandom_range(99) < 10) ? $urandom_range(40, 120) : $urandom_range(1, 24);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) begin
        b = 8'($urandom);
        send_table(b, random_word());
      end else begin
        b = loaded_list[$urandom_range(loaded_list.size() - 1)];
      end
      send_data(b, i == len - 1);
    end
  endtask

  task automatic cfg_write(input cdc_pkg::cfg_reg_e reg_sel, input logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] min_len, input logic [31:0] avg_len,
                            input logic [63:0] mask_small, input logic [63:0] mask_large);
    cfg_write(cdc_pkg::RegMinLen, {32'd0, min_len});
    cfg_write(cdc_pkg::RegAvgLen, {32'd0, avg_len});
    cfg_write(cdc_pkg::RegMaskSmall, mask_small);
    cfg_write(cdc_pkg::RegMaskLarge, mask_large);
  endtask

  // Stop offering, wait for every expected chunk, then cover the pipeline
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (idle_mode)
          IdleReceiver: m_axis_tready <= $urandom_range(99) >= 87;
          IdleBoth:     m_axis_tready <= $urandom_range(99) >= 9;
          default:      m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : stimulus
    idle_e       phase_idle [PhaseCount];
    int unsigned phase_start;
    int unsigned drained;
    logic [31:0] min_len;
    phase_idle = '{IdleNone, IdleSender, IdleReceiver, IdleBoth,
                   IdleBoth, IdleNone, IdleReceiver, IdleSender};
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = cdc_pkg::ModeTable;
    s_axis_tlast  = 1'b0;
    flush         = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // Load extreme gear words; reset registers allow no cut, so buffers only flush
    send_table(8'h00, 64'd0);
    send_table(8'hFF, '1);
    send_table(8'h55, 64'h5555_5555_5555_5555);
    send_table(8'hAA, 64'hAAAA_AAAA_AAAA_AAAA);
    send_data(8'h00, 1'b0);
    send_data(8'hFF, 1'b0);
    send_data(8'h55, 1'b1);
    send_data(8'hAA, 1'b1);
    settle();

    // Zero masks with no minimum: every byte cuts, the last one as final chunk
    set_config(32'd0, 32'd0, 64'd0, 64'd0);
    send_data(8'h00, 1'b0);
    send_data(8'hFF, 1'b0);
    send_data(8'h55, 1'b0);
    send_data(8'hAA, 1'b1);
    settle();

    // Full small mask: cut only on a zero hash once the minimum is reached, then on every byte from the average on
    set_config(32'd2, 32'd4, '1, 64'd0);
    repeat (5) send_data(8'h00, 1'b0);
    send_data(8'h00, 1'b1);
    send_data(8'hFF, 1'b0);
    send_data(8'h55, 1'b0);
    send_data(8'hAA, 1'b0);
    send_data(8'hFF, 1'b1);
    settle();

    // Random phases over several register settings and idle patterns
    for (int phase = 0; phase < PhaseCount; phase++) begin
      idle_mode = phase_idle[phase];
      case (phase)
        4: set_config('1, 32'd0, sparse_mask(4), sparse_mask(2));
        5: set_config(32'd0, '1, 64'd0, '1);
        6: set_config($urandom_range(16), 32'd0, '1, sparse_mask(2));
        default: begin
          min_len = $urandom_range(24);
          set_config(min_len, min_len + $urandom_range(32), sparse_mask(4), sparse_mask(2));
        end
      endcase
      // Every byte cuts here, so a long hold-off backs the block up
      if (phase == 5) hold_reqs++;
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) send_random_buffer();
      settle();
    end

    // Drain, then declare whatever is left as missing
    idle_mode = IdleNone;
    drained = 0;
    while (pending != 0 && drained < DrainLimit) begin
      @(negedge clk_i);
      drained++;
    end
    repeat (20) @(negedge clk_i);
    flush <= 1'b1;
    @(negedge clk_i);
    flush <= 1'b0;
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : run_limit
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
